// File: sv/hq_pkg.sv
// Shared codes and types for the binary max-heap priority queue.
package hq_pkg;

    // Operation field of an incoming request.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status field of a result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Classified command passed from the front end to the heap engine.
    typedef logic [1:0] cmd_kind_t;
    localparam cmd_kind_t CMD_PUSH      = 2'd0;
    localparam cmd_kind_t CMD_POP       = 2'd1;
    localparam cmd_kind_t CMD_ERR_EMPTY = 2'd2;
    localparam cmd_kind_t CMD_ERR_FULL  = 2'd3;

    localparam int CMD_KIND_W = 2;

endpackage

// File: sv/hq_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module hq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: sv/hq_cmd_fifo.sv
// Small register FIFO that decouples the front end from the heap engine.
module hq_cmd_fifo #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    level_reg;
    logic [CW-1:0]    level_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (level_reg == CW'(DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: sv/hq_front.sv
// Front end: accepts requests and classifies them against the running entry count.
module hq_front
    import hq_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        operation,
    input  logic signed [KEY_WIDTH-1:0] value,
    output logic                        cmd_push,
    output cmd_kind_t                   cmd_kind,
    output logic        [KEY_WIDTH-1:0] cmd_value,
    input  logic                        cmd_full
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          accept;

    assign full      = cmd_full;
    assign accept    = push && !cmd_full;
    assign cmd_push  = accept;
    assign cmd_value = value;

    // The count here runs ahead of the engine, but every classified command
    // is carried out in order, so it always matches what the engine will see.
    always_comb
    begin
        count_next = count_reg;
        cmd_kind   = CMD_PUSH;
        if (operation == OP_PUSH)
        begin
            if (count_reg == CW'(CAPACITY))
            begin
                cmd_kind = CMD_ERR_FULL;
            end
            else
            begin
                cmd_kind   = CMD_PUSH;
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                cmd_kind = CMD_ERR_EMPTY;
            end
            else
            begin
                cmd_kind   = CMD_POP;
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/hq_back.sv
// Heap engine: sifts keys up or down in the heap RAM and holds the result register.
module hq_back
    import hq_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_empty,
    input  cmd_kind_t                         cmd_kind,
    input  logic        [KEY_WIDTH-1:0]       cmd_value,
    output logic                              cmd_pop,
    input  logic                              pop,
    output logic                              empty,
    output logic signed [KEY_WIDTH-1:0]       popped_value,
    output logic                              popped_valid,
    output logic        [1:0]                 status,
    output logic        [$clog2(CAPACITY+1)-1:0] entry_count,
    output logic signed [KEY_WIDTH-1:0]       top_value
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_DOWN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    cmd_kind_t            kind_reg;
    cmd_kind_t            kind_next;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic [AW-1:0]        pos_reg;
    logic [AW-1:0]        pos_next;
    logic [KEY_WIDTH-1:0] popped_reg;
    logic [KEY_WIDTH-1:0] popped_next;
    logic [KEY_WIDTH-1:0] root_reg;
    logic [KEY_WIDTH-1:0] root_next;

    logic                 res_valid_reg;
    logic [KEY_WIDTH-1:0] res_popped_reg;
    logic                 res_pvalid_reg;
    logic [1:0]           res_status_reg;
    logic [CW-1:0]        res_count_reg;
    logic [KEY_WIDTH-1:0] res_top_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr_a;
    logic [AW-1:0]        ram_raddr_b;
    logic [KEY_WIDTH-1:0] ram_rdata_a;
    logic [KEY_WIDTH-1:0] ram_rdata_b;

    logic                 done;
    logic                 out_free;
    logic [CW-1:0]        count_dec;
    logic [AW-1:0]        tail_idx;
    logic [AW-1:0]        tail_parent;
    logic [AW-1:0]        up_parent;
    logic [AW-1:0]        up_grand;
    logic [IW-1:0]        child_a;
    logic [IW-1:0]        child_b;
    logic [IW-1:0]        count_wide;
    logic                 pick_b;
    logic [AW-1:0]        sel_idx;
    logic [KEY_WIDTH-1:0] sel_val;
    logic [IW-1:0]        next_child_a;
    logic [IW-1:0]        next_child_b;
    logic [1:0]           res_status;

    hq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign out_free    = !res_valid_reg || pop;
    assign count_dec   = count_reg - 1'b1;
    assign tail_idx    = count_reg[AW-1:0];
    assign tail_parent = (tail_idx - 1'b1) >> 1;
    assign up_parent   = (pos_reg - 1'b1) >> 1;
    assign up_grand    = (up_parent - 1'b1) >> 1;

    // Children of the hole during a sift-down; the wider index keeps the
    // bound check against the count exact at the last level.
    assign child_a      = IW'({pos_reg, 1'b1});
    assign child_b      = child_a + 1'b1;
    assign count_wide   = IW'(count_reg);
    assign pick_b       = (child_b < count_wide)
                          && ($signed(ram_rdata_a) < $signed(ram_rdata_b));
    assign sel_idx      = pick_b ? child_b[AW-1:0] : child_a[AW-1:0];
    assign sel_val      = pick_b ? ram_rdata_b : ram_rdata_a;
    assign next_child_a = IW'({sel_idx, 1'b1});
    assign next_child_b = next_child_a + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        popped_next = popped_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = key_reg;
        ram_raddr_a = '0;
        ram_raddr_b = '0;
        cmd_pop     = 1'b0;
        done        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    kind_next = cmd_kind;
                    case (cmd_kind)
                        CMD_PUSH:
                        begin
                            count_next = count_reg + 1'b1;
                            key_next   = cmd_value;
                            pos_next   = tail_idx;
                            if (count_reg == '0)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = cmd_value;
                                done      = 1'b1;
                            end
                            else
                            begin
                                ram_raddr_a = tail_parent;
                                state_next  = S_UP;
                            end
                        end
                        CMD_POP:
                        begin
                            popped_next = root_reg;
                            count_next  = count_dec;
                            if (count_dec == '0)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                ram_raddr_a = count_dec[AW-1:0];
                                state_next  = S_LAST;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // The hole sits at pos; its parent's key arrived from the RAM.
                ram_we = 1'b1;
                if (pos_reg == '0)
                begin
                    done = 1'b1;
                end
                else if ($signed(ram_rdata_a) < $signed(key_reg))
                begin
                    ram_wdata   = ram_rdata_a;
                    pos_next    = up_parent;
                    ram_raddr_a = up_grand;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            S_LAST:
            begin
                key_next    = ram_rdata_a;
                pos_next    = '0;
                ram_raddr_a = AW'(1);
                ram_raddr_b = AW'(2);
                state_next  = S_DOWN;
            end
            S_DOWN:
            begin
                ram_we = 1'b1;
                if (child_a >= count_wide)
                begin
                    done = 1'b1;
                end
                else if ($signed(key_reg) < $signed(sel_val))
                begin
                    ram_wdata   = sel_val;
                    pos_next    = sel_idx;
                    ram_raddr_a = next_child_a[AW-1:0];
                    ram_raddr_b = next_child_b[AW-1:0];
                end
                else
                begin
                    done = 1'b1;
                end
            end
            S_FIN:
            begin
                done = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (done)
        begin
            state_next = out_free ? S_IDLE : S_FIN;
        end
    end

    assign root_next = (ram_we && (ram_waddr == '0)) ? ram_wdata : root_reg;

    always_comb
    begin
        case (kind_next)
            CMD_ERR_EMPTY: res_status = ST_EMPTY;
            CMD_ERR_FULL:  res_status = ST_FULL;
            default:       res_status = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            kind_reg      <= CMD_PUSH;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
            if (done && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        popped_reg <= popped_next;
        root_reg   <= root_next;
        if (done && out_free)
        begin
            res_pvalid_reg <= (kind_next == CMD_POP);
            res_popped_reg <= (kind_next == CMD_POP) ? popped_next : '0;
            res_status_reg <= res_status;
            res_count_reg  <= count_next;
            res_top_reg    <= (count_next == '0) ? '0 : root_next;
        end
    end

    assign empty        = !res_valid_reg;
    assign popped_value = res_popped_reg;
    assign popped_valid = res_pvalid_reg;
    assign status       = res_status_reg;
    assign entry_count  = res_count_reg;
    assign top_value    = res_top_reg;

endmodule

// File: sv/binary_max_heap_queue.sv
// Binary max-heap priority queue: front end, command FIFO and heap engine.
// The engine takes one request at a time from the command FIFO. A push reads the parent of
// the new tail and rises level by level while its key is larger; a pop reads the last entry,
// moves it into the root hole and sinks it level by level; a rejected request, a push into an
// empty heap or a pop of the last entry finishes from idle; it waits while a result is held.
// Reset clears the counts, FIFO and result valid flag; the heap RAM is not cleared.
module binary_max_heap_queue
    import hq_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 operation,
    input  logic signed [KEY_WIDTH-1:0]          value,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [KEY_WIDTH-1:0]          popped_value,
    output logic                                 popped_valid,
    output logic        [1:0]                    status,
    output logic        [$clog2(CAPACITY+1)-1:0] entry_count,
    output logic signed [KEY_WIDTH-1:0]          top_value
);

    localparam int CMD_W = CMD_KIND_W + KEY_WIDTH;

    logic                 front_push;
    cmd_kind_t            front_kind;
    logic [KEY_WIDTH-1:0] front_value;
    logic                 fifo_full;
    logic                 fifo_empty;
    logic                 fifo_pop;
    logic [CMD_W-1:0]     fifo_rdata;
    cmd_kind_t            back_kind;
    logic [KEY_WIDTH-1:0] back_value;

    hq_front #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .value     (value),
        .cmd_push  (front_push),
        .cmd_kind  (front_kind),
        .cmd_value (front_value),
        .cmd_full  (fifo_full)
    );

    hq_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata ({front_kind, front_value}),
        .full  (fifo_full),
        .pop   (fifo_pop),
        .rdata (fifo_rdata),
        .empty (fifo_empty)
    );

    assign back_kind  = fifo_rdata[CMD_W-1:KEY_WIDTH];
    assign back_value = fifo_rdata[KEY_WIDTH-1:0];

    hq_back #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (fifo_empty),
        .cmd_kind     (back_kind),
        .cmd_value    (back_value),
        .cmd_pop      (fifo_pop),
        .pop          (pop),
        .empty        (empty),
        .popped_value (popped_value),
        .popped_valid (popped_valid),
        .status       (status),
        .entry_count  (entry_count),
        .top_value    (top_value)
    );

endmodule
